// File: rtl/hfw_pkg.sv
// ----------------------------------------------------------------------------
// hfw_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte step for the heartbeat
// frame watchdog.
// ----------------------------------------------------------------------------
package hfw_pkg;

  localparam logic [15:0] CCITT_GEN     = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_TOP       = 16'h8000;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [31:0] TICKS_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REASON_NONE   = 2'd0,
    REASON_CRC    = 2'd1,
    REASON_REPEAT = 2'd2
  } reason_e;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_FRAME = 1'b1
  } req_e;

  // Item held in the input register; the marker is already folded into crc_mid.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  seq;
    logic [15:0] crc_mid;
    logic [15:0] rx_crc;
  } hfw_item_t;

  typedef struct packed {
    logic    frame_accepted;
    reason_e reject_reason;
    logic    expired;
  } hfw_result_t;

  // One byte of MSB-first CRC-16, polynomial 0x1021.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CCITT_GEN;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// File: rtl/heartbeat_frame_watchdog.sv
// ----------------------------------------------------------------------------
// heartbeat_frame_watchdog
// Checks CRC-protected heartbeat frames and keeps a tick-based watchdog.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   in       | in_valid_i / in_ready_o    | req_type, frame_marker/seq/crc
//   out      | out_valid_o / out_ready_i  | frame_accepted, reject_reason,
//            |                            | expired
//   cfg      | cfg_we_i (no wait)         | cfg_wdata_i -> timeout_ticks
//
// One beat per cycle while out is not stalled; each beat passes through the
// input register, then the result register. The marker byte is folded
// into the CRC on the way into the input register, the sequence byte on the
// way into the result register. Reset clears the watchdog state and loads a
// timeout of 1000. A stall on out holds the result register, and the input
// register once it is full; in keeps taking beats while the input register
// is empty or moving on.
// ----------------------------------------------------------------------------
module heartbeat_frame_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  frame_marker_i,
  input  logic [7:0]  frame_seq_i,
  input  logic [15:0] frame_crc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_accepted_o,
  output logic [1:0]  reject_reason_o,
  output logic        expired_o
);
  import hfw_pkg::*;

  logic [31:0]  timeout_q;
  logic         in_valid_q;
  hfw_item_t    item_q, item_d;
  logic         out_valid_q;
  hfw_result_t  result_q, result_d;
  logic         out_free;
  logic         advance;
  logic         in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign item_d.req_type = req_type_i;
  assign item_d.seq      = frame_seq_i;
  assign item_d.crc_mid  = crc_byte(CRC_INIT, frame_marker_i);
  assign item_d.rx_crc   = frame_crc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_d;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  hfw_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .timeout_i (timeout_q),
    .result_o  (result_d)
  );

  assign out_valid_o      = out_valid_q;
  assign frame_accepted_o = result_q.frame_accepted;
  assign reject_reason_o  = result_q.reject_reason;
  assign expired_o        = result_q.expired;

endmodule

// File: rtl/hfw_core.sv
// ----------------------------------------------------------------------------
// hfw_core
// Frame check and watchdog state: finishes the CRC on the sequence byte,
// checks for repeats, advances or clears the tick counter, flags expiry.
// ----------------------------------------------------------------------------
module hfw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  hfw_pkg::hfw_item_t  item_i,
  input  logic [31:0]         timeout_i,
  output hfw_pkg::hfw_result_t result_o
);
  import hfw_pkg::*;

  logic [31:0] elapsed_q, elapsed_d;
  logic [7:0]  last_seq_q, last_seq_d;
  logic        seen_q, seen_d;
  logic [15:0] crc_calc;
  logic        take_frame;

  assign crc_calc = crc_byte(item_i.crc_mid, item_i.seq);

  always_comb begin
    elapsed_d   = elapsed_q;
    last_seq_d  = last_seq_q;
    seen_d      = seen_q;
    take_frame  = 1'b0;
    result_o.reject_reason = REASON_NONE;
    if (item_i.req_type == REQ_FRAME) begin
      if (crc_calc != item_i.rx_crc) begin
        result_o.reject_reason = REASON_CRC;
      end else if (seen_q && (item_i.seq == last_seq_q)) begin
        result_o.reject_reason = REASON_REPEAT;
      end else begin
        take_frame = 1'b1;
        last_seq_d = item_i.seq;
        seen_d     = 1'b1;
        elapsed_d  = '0;
      end
    end else if (elapsed_q != TICKS_MAX) begin
      // saturate at the top instead of wrapping
      elapsed_d = elapsed_q + 32'd1;
    end
    result_o.frame_accepted = take_frame;
    result_o.expired        = (elapsed_d > timeout_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      last_seq_q <= '0;
      seen_q     <= 1'b0;
    end else if (advance_i) begin
      elapsed_q  <= elapsed_d;
      last_seq_q <= last_seq_d;
      seen_q     <= seen_d;
    end
  end

endmodule

// File: rtl/hfw_checker.sv
// ----------------------------------------------------------------------------
// hfw_checker
// Port-level checks for the heartbeat frame watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module hfw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        frame_accepted_o,
  input logic [1:0]  reject_reason_o
);
  import hfw_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted frame carries no reject reason
  a_acc_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_accepted_o |-> reject_reason_o == REASON_NONE)
    else $error("accepted frame with reject reason");

  // reason code three is never produced
  a_reason_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reject_reason_o == REASON_NONE ||
      reject_reason_o == REASON_CRC || reject_reason_o == REASON_REPEAT)
    else $error("unknown reject reason");

  // an empty result register never blocks the input
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

endmodule

bind heartbeat_frame_watchdog hfw_checker u_hfw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_accepted_o (frame_accepted_o),
  .reject_reason_o  (reject_reason_o)
);
